// File: rtl/hypergraph_edge_table_unit_defines.svh
// assertion helpers used by hypergraph_edge_table_unit
`ifndef HYPERGRAPH_EDGE_TABLE_UNIT_DEFINES_SVH
`define HYPERGRAPH_EDGE_TABLE_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define HET_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle check");

// condition holds in the cycle after the trigger
`define HET_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/het_pkg.sv
package het_pkg;

  localparam int unsigned MAX_EDGES = 256;
  localparam int unsigned MAX_VERTS = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_EDGES);
  localparam int unsigned VIDX_W    = $clog2(MAX_VERTS);
  localparam int unsigned FILL_W    = 9;
  localparam int unsigned VCNT_W    = 7;

  typedef logic [MAX_VERTS-1:0] vset_t;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_HIT   = 3'd2;
  localparam logic [2:0] REQ_COV   = 3'd3;
  localparam logic [2:0] REQ_DEG   = 3'd4;
  localparam logic [2:0] REQ_UNION = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // running results of one pass over the table
  typedef struct packed {
    logic              bad;
    logic              hit_all;
    logic              cov_any;
    logic [FILL_W-1:0] deg;
    vset_t             uni;
  } acc_t;

  function automatic vset_t active_mask(input logic [VCNT_W-1:0] vc);
    vset_t m;
    if (vc >= VCNT_W'(MAX_VERTS)) begin
      m = '1;
    end else begin
      m = (vset_t'(1) << vc[VIDX_W-1:0]) - vset_t'(1);
    end
    return m;
  endfunction

endpackage

// File: rtl/het_edge_ram.sv
module het_edge_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [het_pkg::ADDR_W-1:0] waddr_i,
  input  het_pkg::vset_t           wdata_i,
  input  logic                     re_i,
  input  logic [het_pkg::ADDR_W-1:0] raddr_i,
  output het_pkg::vset_t           rdata_o
);

  het_pkg::vset_t mem [het_pkg::MAX_EDGES];
  het_pkg::vset_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/het_scan_acc.sv
module het_scan_acc (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           init_i,
  input  logic           en_i,
  input  het_pkg::vset_t edge_i,
  input  het_pkg::vset_t set_i,
  input  het_pkg::vset_t mask_i,
  input  het_pkg::vset_t bit_i,
  output het_pkg::acc_t  acc_o
);

  het_pkg::acc_t  acc_q, acc_d;
  het_pkg::vset_t e;

  always_comb begin
    e     = edge_i & mask_i;
    acc_d = acc_q;
    if (init_i) begin
      acc_d.bad     = 1'b0;
      acc_d.hit_all = 1'b1;
      acc_d.cov_any = 1'b0;
      acc_d.deg     = '0;
      acc_d.uni     = '0;
    end else if (en_i) begin
      // equal edges count as subsets
      acc_d.bad     = acc_q.bad | ((e & ~set_i) == '0) | ((set_i & ~e) == '0);
      acc_d.hit_all = acc_q.hit_all & ((e & set_i) != '0);
      acc_d.cov_any = acc_q.cov_any | ((e & ~set_i) == '0);
      acc_d.deg     = acc_q.deg + het_pkg::FILL_W'(|(edge_i & bit_i));
      acc_d.uni     = acc_q.uni | e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_d;

endmodule

// File: rtl/hypergraph_edge_table_unit.sv
// latency: clear, add without check and requests on an empty table answer 1 cycle after start
// queries and checked adds read one stored edge per cycle: result fill + 2 cycles after start
// throughput: one request per cycle without a pass, one per fill + 2 cycles with a pass
// busy_o is high while the pass runs; the done_o strobe cannot be stalled
// reset empties the table and sets vertex_count to 64; edge memory contents stay undefined
`include "hypergraph_edge_table_unit_defines.svh"

module hypergraph_edge_table_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   req_type_i,
  input  logic [63:0]                  vertex_set_i,
  input  logic                         check_simple_i,
  input  logic [5:0]                   vertex_index_i,
  input  logic                         vertex_count_we_i,
  input  logic [het_pkg::VCNT_W-1:0]   vertex_count_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic                         answer_flag_o,
  output logic [8:0]                   degree_o,
  output logic [63:0]                  covered_mask_o,
  output logic [8:0]                   edge_total_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [het_pkg::VCNT_W-1:0]   vcount_q;
  logic [het_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [het_pkg::ADDR_W-1:0]   idx_q, idx_d;
  logic                         rd_vld_q;
  logic [2:0]                   req_q, req_d;
  het_pkg::vset_t               set_q, set_d, bit_q, bit_d, mask;

  logic                         done_q, done_d;
  logic [1:0]                   status_q, status_d;
  logic                         flag_q, flag_d;
  logic [8:0]                   deg_q, deg_d;
  het_pkg::vset_t               uni_q, uni_d;
  logic [8:0]                   total_q, total_d;

  logic                         accept, full, empty, need_scan, last_idx;
  logic                         ram_we, ram_re;
  het_pkg::vset_t               ram_wdata, ram_rdata, in_set;
  het_pkg::acc_t                acc;

  assign mask   = het_pkg::active_mask(vcount_q);
  assign in_set = vertex_set_i & mask;
  assign accept = start_i & ~busy_o;
  assign full   = (fill_q == het_pkg::FILL_W'(het_pkg::MAX_EDGES));
  assign empty  = (fill_q == '0);
  assign last_idx = ({1'b0, idx_q} == fill_q - het_pkg::FILL_W'(1));

  always_comb begin
    need_scan = 1'b0;
    case (req_type_i)
      het_pkg::REQ_ADD:   need_scan = check_simple_i & ~full & ~empty;
      het_pkg::REQ_HIT,
      het_pkg::REQ_COV,
      het_pkg::REQ_DEG,
      het_pkg::REQ_UNION: need_scan = ~empty;
      default:            need_scan = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    req_d     = req_q;
    set_d     = set_q;
    bit_d     = bit_q;
    done_d    = 1'b0;
    status_d  = het_pkg::ST_OK;
    flag_d    = 1'b0;
    deg_d     = '0;
    uni_d     = '0;
    total_d   = total_q;
    ram_we    = 1'b0;
    ram_wdata = in_set;
    ram_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_type_i;
          set_d = in_set;
          bit_d = (het_pkg::vset_t'(1) << vertex_index_i) & mask;
          idx_d = '0;
          if (need_scan) begin
            state_d = S_SCAN;
          end else begin
            done_d = 1'b1;
            case (req_type_i)
              het_pkg::REQ_CLEAR: fill_d = '0;
              het_pkg::REQ_ADD: begin
                if (full) begin
                  status_d = het_pkg::ST_FULL;
                end else begin
                  ram_we = 1'b1;
                  fill_d = fill_q + het_pkg::FILL_W'(1);
                end
              end
              // empty table meets the hitting condition trivially
              het_pkg::REQ_HIT:   flag_d = 1'b1;
              default:            flag_d = 1'b0;
            endcase
            total_d = fill_d;
          end
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        idx_d  = idx_q + het_pkg::ADDR_W'(1);
        if (last_idx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d   = S_IDLE;
        done_d    = 1'b1;
        ram_wdata = set_q;
        case (req_q)
          het_pkg::REQ_ADD: begin
            if (acc.bad) begin
              status_d = het_pkg::ST_CONFLICT;
            end else begin
              ram_we = 1'b1;
              fill_d = fill_q + het_pkg::FILL_W'(1);
            end
          end
          het_pkg::REQ_HIT:   flag_d = acc.hit_all;
          het_pkg::REQ_COV:   flag_d = acc.cov_any;
          het_pkg::REQ_DEG:   deg_d  = acc.deg;
          het_pkg::REQ_UNION: uni_d  = acc.uni;
          default:            flag_d = 1'b0;
        endcase
        total_d = fill_d;
      end
      default: state_d = S_IDLE;
    endcase
  end

  het_edge_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[het_pkg::ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  het_scan_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (accept),
    .en_i   (rd_vld_q),
    .edge_i (ram_rdata),
    .set_i  (set_q),
    .mask_i (mask),
    .bit_i  (bit_q),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vcount_q <= het_pkg::VCNT_W'(het_pkg::MAX_VERTS);
      fill_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      rd_vld_q <= ram_re;
      done_q   <= done_d;
      total_q  <= total_d;
      if (vertex_count_we_i) begin
        vcount_q <= vertex_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    set_q    <= set_d;
    bit_q    <= bit_d;
    status_q <= status_d;
    flag_q   <= flag_d;
    deg_q    <= deg_d;
    uni_q    <= uni_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign answer_flag_o  = flag_q;
  assign degree_o       = deg_q;
  assign covered_mask_o = uni_q;
  assign edge_total_o   = total_q;

  `HET_ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= het_pkg::FILL_W'(het_pkg::MAX_EDGES))
  `HET_ASSERT_SAME(a_ram_port_excl, clk_i, rst_ni, ram_we, !ram_re)
  `HET_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, accept, done_o || busy_o)
  `HET_ASSERT_NEXT(a_direct_done, clk_i, rst_ni, accept && !need_scan, done_o)

endmodule
